>>> hw/rtl/mp2_pkg.sv
`default_nettype none

package mp2_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 9;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;
   typedef logic [CSR_DATA_BITS-1:0]  csr_data_type;

   localparam csr_index_type CSR_POOL_MODE     = 2'd0;
   localparam csr_index_type CSR_OUT_WIDTH     = 2'd1;
   localparam csr_index_type CSR_OUT_HEIGHT    = 2'd2;
   localparam csr_index_type CSR_CHANNEL_COUNT = 2'd3;

   localparam logic MODE_2X2 = 1'b0;
   localparam logic MODE_1X2 = 1'b1;

   typedef struct packed {
      logic mode_1x2;
      logic col_phase;
      logic row_phase;
      logic col_end;
      logic row_end;
      logic chan_end;
   } pos_type;

endpackage

`default_nettype wire

>>> hw/rtl/mp2_line_buf.sv
`default_nettype none

module mp2_line_buf #(
   parameter int DEPTH     = 128,
   parameter int ADDR_BITS = 7,
   parameter int DATA_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [DATA_BITS-1:0] wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [DATA_BITS-1:0] rd_data
);

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mp2_pos_ctrl.sv
`default_nettype none

module mp2_pos_ctrl #(
   parameter int MAX_OUT_WIDTH = 128,
   parameter int ADDR_BITS     = 7
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire mp2_pkg::csr_index_type csr_index,
   input  wire mp2_pkg::csr_data_type  csr_wdata,
   input  wire logic                  step,
   output mp2_pkg::pos_type           pos,
   output logic [ADDR_BITS-1:0]       col
);

   logic                 pool_mode_ff, pool_mode_in;
   logic [7:0]           out_width_ff, out_width_in;
   logic [7:0]           out_height_ff, out_height_in;
   logic [8:0]           channel_count_ff, channel_count_in;

   logic [ADDR_BITS-1:0] col_ff, col_in;
   logic [7:0]           row_ff, row_in;
   logic [7:0]           chan_ff, chan_in;
   logic                 col_phase_ff, col_phase_in;
   logic                 row_phase_ff, row_phase_in;

   logic [31:0]          width_ext;
   logic [ADDR_BITS-1:0] col_last;
   logic [7:0]           row_last;
   logic [7:0]           chan_last;
   logic                 col_end, row_end, chan_end, next_chan;

   // effective limits
   always_comb begin
      width_ext = 32'(out_width_ff);
      if (width_ext == 32'd0) begin
         col_last = '0;
      end else if (width_ext > 32'(MAX_OUT_WIDTH)) begin
         col_last = ADDR_BITS'(MAX_OUT_WIDTH - 1);
      end else begin
         col_last = ADDR_BITS'(width_ext - 32'd1);
      end
      row_last = (out_height_ff == 8'd0) ? 8'd0 : out_height_ff - 8'd1;
      if (channel_count_ff == 9'd0) begin
         chan_last = 8'd0;
      end else if (channel_count_ff[8]) begin
         chan_last = 8'hFF;
      end else begin
         chan_last = channel_count_ff[7:0] - 8'd1;
      end
   end

   assign col_end  = (col_ff == col_last);
   assign row_end  = (row_ff == row_last);
   assign chan_end = (chan_ff == chan_last);

   always_comb begin
      pool_mode_in     = pool_mode_ff;
      out_width_in     = out_width_ff;
      out_height_in    = out_height_ff;
      channel_count_in = channel_count_ff;
      col_in           = col_ff;
      row_in           = row_ff;
      chan_in          = chan_ff;
      col_phase_in     = col_phase_ff;
      row_phase_in     = row_phase_ff;
      next_chan        = 1'b0;
      if (csr_write) begin
         case (csr_index)
            mp2_pkg::CSR_POOL_MODE:     pool_mode_in     = csr_wdata[0];
            mp2_pkg::CSR_OUT_WIDTH:     out_width_in     = csr_wdata[7:0];
            mp2_pkg::CSR_OUT_HEIGHT:    out_height_in    = csr_wdata[7:0];
            mp2_pkg::CSR_CHANNEL_COUNT: channel_count_in = csr_wdata;
            default:                    ;
         endcase
         // any write starts a new layer
         col_in       = '0;
         row_in       = 8'd0;
         chan_in      = 8'd0;
         col_phase_in = 1'b0;
         row_phase_in = 1'b0;
      end else if (step) begin
         col_phase_in = ~col_phase_ff;
         if (col_phase_ff) begin
            if (col_end) begin
               col_in = '0;
               if (pool_mode_ff == mp2_pkg::MODE_2X2) begin
                  row_phase_in = ~row_phase_ff;
                  if (row_phase_ff) begin
                     if (row_end) begin
                        row_in    = 8'd0;
                        next_chan = 1'b1;
                     end else begin
                        row_in = row_ff + 8'd1;
                     end
                  end
               end else begin
                  next_chan = 1'b1;
               end
               if (next_chan) begin
                  chan_in = chan_end ? 8'd0 : chan_ff + 8'd1;
               end
            end else begin
               col_in = col_ff + ADDR_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_mode_ff     <= mp2_pkg::MODE_2X2;
         out_width_ff     <= 8'd1;
         out_height_ff    <= 8'd1;
         channel_count_ff <= 9'd1;
         col_ff           <= '0;
         row_ff           <= 8'd0;
         chan_ff          <= 8'd0;
         col_phase_ff     <= 1'b0;
         row_phase_ff     <= 1'b0;
      end else begin
         pool_mode_ff     <= pool_mode_in;
         out_width_ff     <= out_width_in;
         out_height_ff    <= out_height_in;
         channel_count_ff <= channel_count_in;
         col_ff           <= col_in;
         row_ff           <= row_in;
         chan_ff          <= chan_in;
         col_phase_ff     <= col_phase_in;
         row_phase_ff     <= row_phase_in;
      end
   end

   assign pos.mode_1x2  = (pool_mode_ff == mp2_pkg::MODE_1X2);
   assign pos.col_phase = col_phase_ff;
   assign pos.row_phase = row_phase_ff;
   assign pos.col_end   = col_end;
   assign pos.row_end   = row_end;
   assign pos.chan_end  = chan_end;
   assign col           = col_ff;

endmodule

`default_nettype wire

>>> hw/rtl/max_pool_2x2_or_2x1_stream.sv
// result is registered, valid in the cycle after the beat that closes a window
// throughput: one sample per cycle unless stalled; a result per 2 samples (1x2), per 2 of every 2nd row (2x2)
// line buffer is a one-port-write one-port-read ram, read on the first sample of a pair
// reset: synchronous, clears position, config to 2x2 / 1 / 1 / 1 and output valid
// line buffer contents are not cleared; each entry is written before its read value is used
`default_nettype none

module max_pool_2x2_or_2x1_stream #(
   parameter int MAX_OUT_WIDTH = 128,
   parameter int DATA_BITS     = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic signed [DATA_BITS-1:0] req_sample,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [DATA_BITS-1:0]      rsp_pooled_value,
   output logic                             rsp_layer_last,
   input  wire logic                        csr_write,
   input  wire mp2_pkg::csr_index_type      csr_index,
   input  wire mp2_pkg::csr_data_type       csr_wdata
);

   localparam int ADDR_BITS = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

   mp2_pkg::pos_type            pos;
   logic [ADDR_BITS-1:0]        col;
   logic                        accept, emit_pending, emit;
   logic signed [DATA_BITS-1:0] pair_max_ff, pair_max_in;
   logic signed [DATA_BITS-1:0] pair_m, upper, result;
   logic [DATA_BITS-1:0]        rd_data;
   logic                        buf_wr, buf_rd;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_BITS-1:0] rsp_value_ff;
   logic                        rsp_last_ff;

   assign emit_pending = pos.col_phase & (pos.mode_1x2 | pos.row_phase);
   // only a window-closing beat needs room in the output register
   assign req_stall    = rsp_valid_ff & rsp_stall & emit_pending;
   assign accept       = req_valid & ~req_stall;
   assign emit         = accept & emit_pending;

   mp2_pos_ctrl #(
      .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
      .ADDR_BITS    (ADDR_BITS)
   ) u_pos (
      .clock    (clock),
      .reset    (reset),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .step     (accept),
      .pos      (pos),
      .col      (col)
   );

   assign buf_rd = accept & ~pos.col_phase;
   assign buf_wr = accept & pos.col_phase & ~pos.mode_1x2 & ~pos.row_phase;

   mp2_line_buf #(
      .DEPTH    (MAX_OUT_WIDTH),
      .ADDR_BITS(ADDR_BITS),
      .DATA_BITS(DATA_BITS)
   ) u_buf (
      .clock  (clock),
      .wr_en  (buf_wr),
      .wr_addr(col),
      .wr_data(pair_m),
      .rd_en  (buf_rd),
      .rd_addr(col),
      .rd_data(rd_data)
   );

   // pair and window maxima
   always_comb begin
      pair_max_in = pair_max_ff;
      if (accept && !pos.col_phase) begin
         if (!pos.mode_1x2 && req_sample[DATA_BITS-1]) begin
            pair_max_in = '0;
         end else begin
            pair_max_in = req_sample;
         end
      end
      pair_m = (req_sample > pair_max_ff) ? req_sample : pair_max_ff;
      upper  = $signed(rd_data);
      if (pos.mode_1x2) begin
         result = pair_m;
      end else begin
         result = (upper > pair_m) ? upper : pair_m;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pair_max_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pair_max_ff  <= pair_max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff <= result;
         rsp_last_ff  <= pos.col_end & pos.chan_end & (pos.mode_1x2 | pos.row_end);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pooled_value = rsp_value_ff;
   assign rsp_layer_last   = rsp_last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mp2_checker.sv
`default_nettype none

module mp2_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // input is held back only by a full, stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output back-pressure");

   // every new result follows an accepted sample
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("result appeared without an accepted sample");

   // output empty right after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind max_pool_2x2_or_2x1_stream mp2_checker u_mp2_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall)
);

`default_nettype wire

>>> bench/max_pool_2x2_or_2x1_stream_checker.sv
module max_pool_2x2_or_2x1_stream_checker #(
   parameter int MAX_OUT_WIDTH = 128,
   parameter int DATA_BITS     = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic signed [DATA_BITS-1:0] req_sample,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic signed [DATA_BITS-1:0] rsp_pooled_value,
   input  logic                        rsp_layer_last,
   input  logic                        csr_write,
   input  mp2_pkg::csr_index_type      csr_index,
   input  mp2_pkg::csr_data_type       csr_wdata,
   output int                          error_count,
   output int                          pending_count
);

   localparam int MAX_CHANNELS = 256;

   typedef struct packed {
      logic signed [DATA_BITS-1:0] value;
      logic                        layer_last;
   } pooled_beat_type;

   pooled_beat_type expected_beats[$];

   int mismatches = 0;
   int waiting = 0;

   logic                        pool_mode;
   logic [7:0]                  width_reg;
   logic [7:0]                  height_reg;
   logic [8:0]                  chan_reg;
   logic signed [DATA_BITS-1:0] row_max [MAX_OUT_WIDTH];
   logic signed [DATA_BITS-1:0] pair_max;
   int unsigned                 col_count;
   int unsigned                 row_count;
   int unsigned                 chan_index;
   bit                          col_half;
   bit                          row_half;

   assign error_count   = mismatches;
   assign pending_count = waiting;

   task automatic clear_position();
      pair_max   = '0;
      col_count  = 0;
      row_count  = 0;
      chan_index = 0;
      col_half   = 1'b0;
      row_half   = 1'b0;
   endtask

   task automatic predict_pool(input logic signed [DATA_BITS-1:0] sample);
      int unsigned                 w;
      int unsigned                 h;
      int unsigned                 c;
      int unsigned                 col;
      logic signed [DATA_BITS-1:0] m;
      logic signed [DATA_BITS-1:0] up;
      logic signed [DATA_BITS-1:0] pooled;
      bit                          emit;
      bit                          last;
      bit                          col_end;
      bit                          next_chan;
      w = (width_reg == 0) ? 1 : ((width_reg > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      c = (chan_reg == 0) ? 1 : ((chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : chan_reg);
      col = (col_count < MAX_OUT_WIDTH) ? col_count : 0;
      if (!col_half) begin
         // first of a pair, 2x2 mode floors it at zero
         pair_max = (pool_mode == mp2_pkg::MODE_2X2 && sample < 0) ? '0 : sample;
         col_half = 1'b1;
         return;
      end
      m = (sample > pair_max) ? sample : pair_max;
      col_half = 1'b0;
      emit = 1'b0;
      last = 1'b0;
      pooled = '0;
      col_end = (col + 1 >= w);
      if (pool_mode == mp2_pkg::MODE_2X2) begin
         if (!row_half) begin
            row_max[col] = m;
         end else begin
            up = row_max[col];
            pooled = (up > m) ? up : m;
            emit = 1'b1;
            last = col_end && (row_count + 1 >= h) && (chan_index + 1 >= c);
         end
      end else begin
         pooled = m;
         emit = 1'b1;
         last = col_end && (chan_index + 1 >= c);
      end
      if (col_end) begin
         col_count = 0;
         next_chan = (pool_mode == mp2_pkg::MODE_1X2);
         if (pool_mode == mp2_pkg::MODE_2X2) begin
            if (!row_half) begin
               row_half = 1'b1;
            end else begin
               row_half = 1'b0;
               if (row_count + 1 >= h) begin
                  row_count = 0;
                  next_chan = 1'b1;
               end else begin
                  row_count++;
               end
            end
         end
         if (next_chan) begin
            chan_index = (chan_index + 1 >= c) ? 0 : chan_index + 1;
         end
      end else begin
         col_count = col + 1;
      end
      if (emit) begin
         expected_beats.push_back('{value: pooled, layer_last: last});
      end
   endtask

   always @(posedge clock) begin : watch
      pooled_beat_type want;
      if (reset) begin
         pool_mode  = mp2_pkg::MODE_2X2;
         width_reg  = 8'd1;
         height_reg = 8'd1;
         chan_reg   = 9'd1;
         clear_position();
         expected_beats.delete();
      end else begin
         // a result beat always comes from an earlier sample, so check first
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected beat, actual value %0d last %0b",
                        $time, rsp_pooled_value, rsp_layer_last);
            end else begin
               want = expected_beats.pop_front();
               if (rsp_pooled_value !== want.value) begin
                  mismatches++;
                  $display("%0t: pooled_value expected %0d actual %0d",
                           $time, want.value, rsp_pooled_value);
               end
               if (rsp_layer_last !== want.layer_last) begin
                  mismatches++;
                  $display("%0t: layer_last expected %0b actual %0b",
                           $time, want.layer_last, rsp_layer_last);
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               mp2_pkg::CSR_POOL_MODE:     pool_mode  = csr_wdata[0];
               mp2_pkg::CSR_OUT_WIDTH:     width_reg  = csr_wdata[7:0];
               mp2_pkg::CSR_OUT_HEIGHT:    height_reg = csr_wdata[7:0];
               mp2_pkg::CSR_CHANNEL_COUNT: chan_reg   = csr_wdata[8:0];
               default: ;
            endcase
            clear_position();
         end
         if (req_valid && !req_stall) begin
            predict_pool(req_sample);
         end
      end
      waiting <= expected_beats.size();
   end

endmodule

>>> bench/max_pool_2x2_or_2x1_stream_tb.sv
module max_pool_2x2_or_2x1_stream_tb;

   localparam int MAX_OUT_WIDTH = 128;
   localparam int DATA_BITS     = 8;
   localparam int RANDOM_ITEMS  = 60;
   localparam int HOLD_CYCLES   = 64;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 8;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic signed [DATA_BITS-1:0] req_sample = '0;
   logic                        rsp_stall = 1'b0;
   logic                        csr_write = 1'b0;
   mp2_pkg::csr_index_type      csr_index = mp2_pkg::CSR_POOL_MODE;
   mp2_pkg::csr_data_type       csr_wdata = '0;

   logic                        req_stall;
   logic                        rsp_valid;
   logic signed [DATA_BITS-1:0] rsp_pooled_value;
   logic                        rsp_layer_last;

   int error_count;
   int pending_count;
   int idle_cycles = 0;
   bit hold_start = 1'b0;

   max_pool_2x2_or_2x1_stream #(
      .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
      .DATA_BITS(DATA_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pooled_value(rsp_pooled_value),
      .rsp_layer_last(rsp_layer_last),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   max_pool_2x2_or_2x1_stream_checker #(
      .MAX_OUT_WIDTH(MAX_OUT_WIDTH),
      .DATA_BITS(DATA_BITS)
   ) pool_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_sample(req_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pooled_value(rsp_pooled_value),
      .rsp_layer_last(rsp_layer_last),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .error_count(error_count),
      .pending_count(pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("max_pool_2x2_or_2x1_stream_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver stall pattern, plus one long hold-off
   initial begin : receiver
      int  cycle_no;
      int  hold_left;
      bit  hold_taken;
      cycle_no = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         cycle_no++;
         if (hold_start && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case ((cycle_no / 128) % 4)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= 1'($urandom_range(0, 1));
               default: rsp_stall <= ((cycle_no % 7) < 3);
            endcase
         end
      end
   end

   task automatic send_sample(input int value);
      req_valid <= 1'b1;
      req_sample <= DATA_BITS'(value);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic stream_samples(input int count, input bit lean_negative);
      int                          burst;
      int                          gap;
      logic signed [DATA_BITS-1:0] value;
      burst = $urandom_range(1, 40);
      for (int i = 0; i < count; i++) begin
         value = DATA_BITS'($urandom);
         if (lean_negative && $urandom_range(0, 3) != 0) begin
            value[DATA_BITS-1] = 1'b1;
         end
         send_sample(value);
         burst--;
         if (burst == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst = $urandom_range(1, 40);
         end
      end
   endtask

   task automatic write_reg(input mp2_pkg::csr_index_type index,
                            input mp2_pkg::csr_data_type data);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // registers change only once the block has drained
   task automatic write_regs(input logic mode, input int width, input int height,
                             input int chans);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_reg(mp2_pkg::CSR_POOL_MODE, {8'($urandom), mode});
      write_reg(mp2_pkg::CSR_OUT_WIDTH, {1'($urandom), 8'(width)});
      write_reg(mp2_pkg::CSR_OUT_HEIGHT, {1'($urandom), 8'(height)});
      write_reg(mp2_pkg::CSR_CHANNEL_COUNT, 9'(chans));
      csr_write <= 1'b0;
   endtask

   initial begin : stimulus
      logic mode;
      int   width;
      int   height;
      int   chans;
      int   eff_w;
      int   eff_h;
      int   eff_c;
      int   count;
      int   small_sent;
      small_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset config: all-negative window floors to zero, then extremes
      send_sample(-128);
      send_sample(-1);
      send_sample(-5);
      send_sample(-7);
      send_sample(127);
      send_sample(-128);
      send_sample(0);
      send_sample(1);

      // pair pooling keeps negatives
      write_regs(mp2_pkg::MODE_1X2, 2, 0, 2);
      send_sample(-128);
      send_sample(-100);
      send_sample(127);
      send_sample(-128);
      send_sample(-1);
      send_sample(-1);
      send_sample(0);
      send_sample(-128);

      // zero sizes act as one; last sample leaves a half pair behind
      write_regs(mp2_pkg::MODE_2X2, 0, 0, 0);
      send_sample(-3);
      send_sample(5);
      send_sample(7);
      send_sample(-9);
      send_sample(100);

      // oversized width and channel count, receiver holds off meanwhile
      write_regs(mp2_pkg::MODE_1X2, 255, 0, 511);
      hold_start = 1'b1;
      stream_samples(32, 1'b0);

      // full line buffer: one row pair at maximum width
      write_regs(mp2_pkg::MODE_2X2, 128, 1, 1);
      stream_samples(4 * MAX_OUT_WIDTH, 1'b0);

      while (small_sent < RANDOM_ITEMS) begin
         mode = 1'($urandom_range(0, 1));
         width = $urandom_range(1, 4);
         height = $urandom_range(1, 3);
         chans = $urandom_range(1, 3);
         case ($urandom_range(0, 7))
            0: width = 0;
            1: height = 0;
            2: chans = 0;
            3: chans = $urandom_range(257, 511);
            default: ;
         endcase
         eff_w = (width == 0) ? 1 : width;
         eff_h = (height == 0) ? 1 : height;
         eff_c = (chans == 0) ? 1 : ((chans > 256) ? 256 : chans);
         count = 2 * eff_w * ((mode == mp2_pkg::MODE_1X2) ? 1 : 2 * eff_h) * eff_c
                 * $urandom_range(1, 2);
         if (count > 60) begin
            count = $urandom_range(20, 60);
         end
         if ($urandom_range(0, 3) == 0) begin
            count += $urandom_range(1, 3);
         end
         write_regs(mode, width, height, chans);
         stream_samples(count, 1'($urandom_range(0, 1)));
         small_sent += count;
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("max_pool_2x2_or_2x1_stream_tb: clean");
      end else begin
         $display("max_pool_2x2_or_2x1_stream_tb: errors");
      end
      $finish;
   end

endmodule
